// ----- hw/rtl/plvc_pkg.sv -----
// ----------------------------------------------------------------------------
// plvc_pkg
// Shared types and constants of the pairwise linear vote classifier: field
// widths, function codes, register indexes and controller command types.
// ----------------------------------------------------------------------------
package plvc_pkg;

	// Default sizing
	localparam int MAX_CLASSES_DEF = 8;
	localparam int BANDS_DEF       = 4;

	// Fixed field widths
	localparam int FUNC_W       = 2;
	localparam int ENTRY_W      = 5;
	localparam int BANDSEL_W    = 2;
	localparam int COEF_W       = 25;
	localparam int COLOR_W      = 24;
	localparam int PIX_W        = 16;
	localparam int PIXEL_INPUTS = 4;
	localparam int OUT_W        = 3;
	localparam int CHAN_W       = 8;

	// Table entry widths
	localparam int NRM_W  = 24;
	localparam int MEAN_W = 24;

	// Configuration
	localparam int CNT_W       = 4;
	localparam int FACTOR_W    = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CNT_W-1:0]    CLASS_COUNT_RST = 4'd8;
	localparam logic [FACTOR_W-1:0] FACTOR_RST      = 16'd19595;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd1;

	// Threshold compare: d is scaled by 2^FRAC_SHIFT, the mean projection is
	// split at SPLIT_W bits so each factor product stays narrow
	localparam int FRAC_SHIFT = 24;
	localparam int SPLIT_W    = 26;

	// Request function codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_CLASSIFY = 2'd0,
		FUNC_NORMAL   = 2'd1,
		FUNC_MEAN     = 2'd2,
		FUNC_COLOR    = 2'd3
	} func_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic issue;
		logic first_band;
		logic last_band;
		logic clear;
		logic scan;
		logic load_out;
	} ctrl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} dp_status_t;

endpackage

// ----- hw/rtl/plvc_ctrl.sv -----
// ----------------------------------------------------------------------------
// plvc_ctrl
// Sequencer of the classifier: takes requests, walks the class pairs and
// bands one coefficient per cycle, waits for the pipeline, scans the vote
// counters and hands the result to the output register.
// ----------------------------------------------------------------------------
module plvc_ctrl #(
	parameter int MAX_CLASSES = plvc_pkg::MAX_CLASSES_DEF,
	parameter int BANDS       = plvc_pkg::BANDS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [plvc_pkg::FUNC_W-1:0]       func,
	input  logic [plvc_pkg::CNT_W-1:0]        class_count,
	input  plvc_pkg::dp_status_t              status,
	output plvc_pkg::ctrl_cmd_t               cmd,
	output logic [$clog2(MAX_CLASSES)-1:0]    cls_i,
	output logic [$clog2(MAX_CLASSES)-1:0]    cls_j,
	output logic [((BANDS > 1) ? $clog2(BANDS) : 1)-1:0] band,
	output logic [((MAX_CLASSES*(MAX_CLASSES-1)/2*BANDS > 1) ?
		$clog2(MAX_CLASSES*(MAX_CLASSES-1)/2*BANDS) : 1)-1:0] naddr,
	output logic [$clog2(MAX_CLASSES)-1:0]    scan_idx
);
	import plvc_pkg::*;

	localparam int CLS_W   = $clog2(MAX_CLASSES);
	localparam int KW      = $clog2(MAX_CLASSES + 1);
	localparam int BAND_W  = (BANDS > 1) ? $clog2(BANDS) : 1;
	localparam int NDEPTH  = MAX_CLASSES * (MAX_CLASSES - 1) / 2 * BANDS;
	localparam int NADDR_W = (NDEPTH > 1) ? $clog2(NDEPTH) : 1;

	state_t state_q, state_d;

	logic [KW-1:0]      k_q;
	logic [KW-1:0]      k_eff;
	logic [KW-1:0]      k_scan;
	logic [CLS_W-1:0]   ci_q, cj_q, sc_q;
	logic [BAND_W-1:0]  band_q;
	logic [NADDR_W-1:0] naddr_q;
	logic               accept;
	logic               is_classify;
	logic               band_last;
	logic               row_last;
	logic               pair_last;
	logic               scan_last;

	assign accept      = in_valid && !in_stall;
	assign is_classify = (func == FUNC_CLASSIFY);

	// Clamp the class count to the table size
	assign k_eff = (KW'(class_count) > KW'(MAX_CLASSES)) ? KW'(MAX_CLASSES)
		: KW'(class_count);
	assign k_scan = (k_q == '0) ? KW'(1) : k_q;

	assign band_last = (band_q == BAND_W'(BANDS - 1));
	assign row_last  = (KW'(cj_q) == k_q - KW'(1));
	assign pair_last = band_last && row_last && (KW'(ci_q) == k_q - KW'(2));
	assign scan_last = (KW'(sc_q) == k_scan - KW'(1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_classify) begin
					state_d = (k_eff >= KW'(2)) ? ST_RUN : ST_SCAN;
				end
			end
			ST_RUN: begin
				if (pair_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_stall       = (state_q != ST_IDLE);
		cmd.accept     = accept;
		cmd.clear      = accept && is_classify;
		cmd.issue      = (state_q == ST_RUN);
		cmd.first_band = (band_q == '0);
		cmd.last_band  = band_last;
		cmd.scan       = (state_q == ST_SCAN);
		cmd.load_out   = (state_q == ST_FINISH) && status.out_free;
	end

	assign cls_i    = ci_q;
	assign cls_j    = cj_q;
	assign band     = band_q;
	assign naddr    = naddr_q;
	assign scan_idx = sc_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Pair, band and scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			ci_q    <= '0;
			cj_q    <= '0;
			band_q  <= '0;
			naddr_q <= '0;
			sc_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && is_classify) begin
						k_q     <= k_eff;
						ci_q    <= '0;
						cj_q    <= CLS_W'(1);
						band_q  <= '0;
						naddr_q <= '0;
						sc_q    <= '0;
					end
				end
				ST_RUN: begin
					naddr_q <= naddr_q + NADDR_W'(1);
					if (band_last) begin
						band_q <= '0;
						if (row_last) begin
							ci_q <= ci_q + CLS_W'(1);
							cj_q <= CLS_W'(KW'(ci_q) + KW'(2));
						end else begin
							cj_q <= cj_q + CLS_W'(1);
						end
					end else begin
						band_q <= band_q + BAND_W'(1);
					end
				end
				ST_SCAN: begin
					if (!scan_last) begin
						sc_q <= sc_q + CLS_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/plvc_datapath.sv -----
// ----------------------------------------------------------------------------
// plvc_datapath
// Coefficient tables, the projection pipeline (read, multiply, accumulate,
// factor products, threshold compare), the vote counters with the winner
// scan, and the output register.
// ----------------------------------------------------------------------------
module plvc_datapath #(
	parameter int MAX_CLASSES = plvc_pkg::MAX_CLASSES_DEF,
	parameter int BANDS       = plvc_pkg::BANDS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [plvc_pkg::FACTOR_W-1:0]     factor,
	input  logic [plvc_pkg::FUNC_W-1:0]       func,
	input  logic [plvc_pkg::ENTRY_W-1:0]      entry_index,
	input  logic [plvc_pkg::BANDSEL_W-1:0]    band_index,
	input  logic signed [plvc_pkg::COEF_W-1:0] coefficient,
	input  logic [plvc_pkg::COLOR_W-1:0]      color_word,
	input  logic [plvc_pkg::PIX_W-1:0]        pixel_band_0,
	input  logic [plvc_pkg::PIX_W-1:0]        pixel_band_1,
	input  logic [plvc_pkg::PIX_W-1:0]        pixel_band_2,
	input  logic [plvc_pkg::PIX_W-1:0]        pixel_band_3,
	input  plvc_pkg::ctrl_cmd_t               cmd,
	input  logic [$clog2(MAX_CLASSES)-1:0]    cls_i,
	input  logic [$clog2(MAX_CLASSES)-1:0]    cls_j,
	input  logic [((BANDS > 1) ? $clog2(BANDS) : 1)-1:0] band,
	input  logic [((MAX_CLASSES*(MAX_CLASSES-1)/2*BANDS > 1) ?
		$clog2(MAX_CLASSES*(MAX_CLASSES-1)/2*BANDS) : 1)-1:0] naddr,
	input  logic [$clog2(MAX_CLASSES)-1:0]    scan_idx,
	output plvc_pkg::dp_status_t              status,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [plvc_pkg::OUT_W-1:0]        class_index,
	output logic [plvc_pkg::OUT_W-1:0]        winning_votes,
	output logic [plvc_pkg::CHAN_W-1:0]       red,
	output logic [plvc_pkg::CHAN_W-1:0]       green,
	output logic [plvc_pkg::CHAN_W-1:0]       blue
);
	import plvc_pkg::*;

	localparam int CLS_W      = $clog2(MAX_CLASSES);
	localparam int VOTE_W     = $clog2(MAX_CLASSES);
	localparam int BAND_W     = (BANDS > 1) ? $clog2(BANDS) : 1;
	localparam int PAIR_LIMIT = MAX_CLASSES * (MAX_CLASSES - 1) / 2;
	localparam int NDEPTH     = PAIR_LIMIT * BANDS;
	localparam int MDEPTH     = MAX_CLASSES * BANDS;
	localparam int NADDR_W    = (NDEPTH > 1) ? $clog2(NDEPTH) : 1;
	localparam int MADDR_W    = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
	localparam int GROW       = (BANDS > 1) ? $clog2(BANDS) : 0;
	localparam int MSUM_W     = MEAN_W + 1;
	localparam int PD_W       = PIX_W + 1 + NRM_W;
	localparam int PS_W       = MSUM_W + 1 + NRM_W;
	localparam int D_W        = PD_W + GROW;
	localparam int S_W        = PS_W + GROW;
	localparam int SHI_W      = S_W - SPLIT_W;
	localparam int LO_W       = FACTOR_W + SPLIT_W;
	localparam int HI_W       = FACTOR_W + 1 + SHI_W;
	localparam int CMP_W      = S_W + FACTOR_W + 2;

	// Tables
	logic [NRM_W-1:0]   nrm_mem [NDEPTH];
	logic [MEAN_W-1:0]  mean_mem [MDEPTH];
	logic [COLOR_W-1:0] color_q [MAX_CLASSES];

	logic [PIX_W-1:0]   pix_q [PIXEL_INPUTS];

	logic               wr_normal, wr_mean, wr_color;
	logic [NADDR_W-1:0] nwr_addr;
	logic [MADDR_W-1:0] mwr_addr;
	logic [MADDR_W-1:0] mi_addr, mj_addr;
	logic [PIX_W-1:0]   pix_sel;

	// Pipeline registers
	logic                     v_s1, first_s1, last_s1;
	logic [CLS_W-1:0]         i_s1, j_s1;
	logic [PIX_W-1:0]         pix_s1;
	logic [NRM_W-1:0]         nrm_s1;
	logic [MEAN_W-1:0]        mi_s1, mj_s1;

	logic                     v_s2, first_s2, last_s2;
	logic [CLS_W-1:0]         i_s2, j_s2;
	logic signed [PD_W-1:0]   pd_s2;
	logic signed [PS_W-1:0]   ps_s2;

	logic                     v_s3;
	logic [CLS_W-1:0]         i_s3, j_s3;
	logic signed [D_W-1:0]    d_acc_s3;
	logic signed [S_W-1:0]    s_acc_s3;

	logic                     v_s4;
	logic [CLS_W-1:0]         i_s4, j_s4;
	logic signed [D_W-1:0]    d_s4;
	logic [LO_W-1:0]          lo_s4;
	logic signed [HI_W-1:0]   hi_s4;

	logic                     v_s5;
	logic [CLS_W-1:0]         i_s5, j_s5;
	logic signed [CMP_W-1:0]  x_s5;
	logic signed [HI_W-1:0]   y_s5;

	logic [MSUM_W-1:0]        msum;
	logic [SPLIT_W-1:0]       s_lo;
	logic signed [SHI_W-1:0]  s_hi;
	logic signed [CMP_W-1:0]  d_ext, lo_ext, y_ext;
	logic                     first_wins;
	logic [CLS_W-1:0]         win_idx;

	// Votes and winner
	logic [VOTE_W-1:0]        votes_q [MAX_CLASSES];
	logic [CLS_W-1:0]         best_q;
	logic [VOTE_W-1:0]        best_votes_q;

	logic                     out_valid_q;
	logic [OUT_W-1:0]         class_q, votes_out_q;
	logic [COLOR_W-1:0]       color_out_q;

	// Decode load requests, drop out-of-range entries
	assign wr_normal = cmd.accept && (func == FUNC_NORMAL)
		&& (32'(entry_index) < PAIR_LIMIT) && (32'(band_index) < BANDS);
	assign wr_mean   = cmd.accept && (func == FUNC_MEAN)
		&& (32'(entry_index) < MAX_CLASSES) && (32'(band_index) < BANDS);
	assign wr_color  = cmd.accept && (func == FUNC_COLOR)
		&& (32'(entry_index) < MAX_CLASSES);
	assign nwr_addr  = NADDR_W'(32'(entry_index) * BANDS + 32'(band_index));
	assign mwr_addr  = MADDR_W'(32'(entry_index) * BANDS + 32'(band_index));
	assign mi_addr   = MADDR_W'(32'(cls_i) * BANDS + 32'(band));
	assign mj_addr   = MADDR_W'(32'(cls_j) * BANDS + 32'(band));

	// Normal table: one write or one read per cycle
	always_ff @(posedge clk) begin
		if (wr_normal) begin
			nrm_mem[nwr_addr] <= coefficient[NRM_W-1:0];
		end
		if (cmd.issue) begin
			nrm_s1 <= nrm_mem[naddr];
		end
	end

	// Mean table: one write port, two read ports
	always_ff @(posedge clk) begin
		if (wr_mean) begin
			mean_mem[mwr_addr] <= coefficient[MEAN_W-1:0];
		end
		if (cmd.issue) begin
			mi_s1 <= mean_mem[mi_addr];
			mj_s1 <= mean_mem[mj_addr];
		end
	end

	// Color table and pixel capture
	always_ff @(posedge clk) begin
		if (wr_color) begin
			color_q[CLS_W'(entry_index)] <= color_word;
		end
		if (cmd.clear) begin
			pix_q[0] <= pixel_band_0;
			pix_q[1] <= pixel_band_1;
			pix_q[2] <= pixel_band_2;
			pix_q[3] <= pixel_band_3;
		end
	end

	// Pick the sample of the issued band, zero past the pixel inputs
	always_comb begin
		pix_sel = '0;
		for (int b = 0; b < PIXEL_INPUTS; b++) begin
			if (32'(band) == b) begin
				pix_sel = pix_q[b];
			end
		end
	end

	assign msum = MSUM_W'(mi_s1) + MSUM_W'(mj_s1);

	// Pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && last_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: tags and sample beside the table reads
	always_ff @(posedge clk) begin
		first_s1 <= cmd.first_band;
		last_s1  <= cmd.last_band;
		i_s1     <= cls_i;
		j_s1     <= cls_j;
		pix_s1   <= pix_sel;
	end

	// Stage 2: pixel and mean products against the normal
	always_ff @(posedge clk) begin
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		i_s2     <= i_s1;
		j_s2     <= j_s1;
		pd_s2    <= $signed({1'b0, pix_s1}) * $signed(nrm_s1);
		ps_s2    <= $signed({1'b0, msum}) * $signed(nrm_s1);
	end

	// Stage 3: accumulate over the bands of a pair
	always_ff @(posedge clk) begin
		if (v_s2) begin
			if (first_s2) begin
				d_acc_s3 <= D_W'(pd_s2);
				s_acc_s3 <= S_W'(ps_s2);
			end else begin
				d_acc_s3 <= d_acc_s3 + D_W'(pd_s2);
				s_acc_s3 <= s_acc_s3 + S_W'(ps_s2);
			end
		end
		if (v_s2 && last_s2) begin
			i_s3 <= i_s2;
			j_s3 <= j_s2;
		end
	end

	// Stage 4: factor times the mean projection, in two halves
	assign s_lo = s_acc_s3[SPLIT_W-1:0];
	assign s_hi = s_acc_s3[S_W-1:SPLIT_W];

	always_ff @(posedge clk) begin
		i_s4  <= i_s3;
		j_s4  <= j_s3;
		d_s4  <= d_acc_s3;
		lo_s4 <= LO_W'(factor) * LO_W'(s_lo);
		hi_s4 <= $signed({1'b0, factor}) * s_hi;
	end

	// Stage 5: fold the low half into the scaled projection
	assign d_ext  = CMP_W'(d_s4);
	assign lo_ext = CMP_W'(lo_s4);

	always_ff @(posedge clk) begin
		i_s5 <= i_s4;
		j_s5 <= j_s4;
		x_s5 <= (d_ext <<< FRAC_SHIFT) - lo_ext;
		y_s5 <= hi_s4;
	end

	// Vote: first class of the pair wins on a strictly greater projection
	assign y_ext      = CMP_W'(y_s5);
	assign first_wins = (x_s5 > (y_ext <<< SPLIT_W));
	assign win_idx    = first_wins ? i_s5 : j_s5;

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			for (int c = 0; c < MAX_CLASSES; c++) begin
				votes_q[c] <= '0;
			end
		end else if (v_s5) begin
			votes_q[win_idx] <= votes_q[win_idx] + VOTE_W'(1);
		end
	end

	// Winner scan, one class a cycle, lowest index kept on equal votes
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			best_q       <= '0;
			best_votes_q <= '0;
		end else if (cmd.scan && (votes_q[scan_idx] > best_votes_q)) begin
			best_q       <= scan_idx;
			best_votes_q <= votes_q[scan_idx];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			class_q     <= OUT_W'(best_q);
			votes_out_q <= OUT_W'(best_votes_q);
			color_out_q <= color_q[best_q];
		end
	end

	assign status.pipe_busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign status.out_free  = !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign class_index   = class_q;
	assign winning_votes = votes_out_q;
	assign red           = color_out_q[3*CHAN_W-1:2*CHAN_W];
	assign green         = color_out_q[2*CHAN_W-1:CHAN_W];
	assign blue          = color_out_q[CHAN_W-1:0];

endmodule

// ----- hw/rtl/pairwise_linear_vote_classifier.sv -----
// ----------------------------------------------------------------------------
// pairwise_linear_vote_classifier
// One-vs-one linear classifier for multispectral pixels: loads normal, mean
// and color tables, votes over all class pairs and returns the winner color.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   func, entry_index, band_index,
//                                           coefficient, color_word,
//                                           pixel_band_0..3
//   out      output     out_valid/out_stall class_index, winning_votes,
//                                           red, green, blue
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A classify request with K >= 2 classes in use walks every class pair and
// band: the single normal-table read port streams one coefficient per cycle,
// then the pipeline drains and the vote counters are scanned. One with fewer
// classes goes straight to the scan.
// Reset sets class_count to 8 and threshold_factor to 19595; the tables
// hold nothing until written. A result waits in the output register while
// out_stall is high; the next result waits in the controller until it frees.
// ----------------------------------------------------------------------------
module pairwise_linear_vote_classifier #(
	parameter int MAX_CLASSES = plvc_pkg::MAX_CLASSES_DEF,
	parameter int BANDS       = plvc_pkg::BANDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [plvc_pkg::FUNC_W-1:0]         func,
	input  logic [plvc_pkg::ENTRY_W-1:0]        entry_index,
	input  logic [plvc_pkg::BANDSEL_W-1:0]      band_index,
	input  logic signed [plvc_pkg::COEF_W-1:0]  coefficient,
	input  logic [plvc_pkg::COLOR_W-1:0]        color_word,
	input  logic [plvc_pkg::PIX_W-1:0]          pixel_band_0,
	input  logic [plvc_pkg::PIX_W-1:0]          pixel_band_1,
	input  logic [plvc_pkg::PIX_W-1:0]          pixel_band_2,
	input  logic [plvc_pkg::PIX_W-1:0]          pixel_band_3,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [plvc_pkg::OUT_W-1:0]          class_index,
	output logic [plvc_pkg::OUT_W-1:0]          winning_votes,
	output logic [plvc_pkg::CHAN_W-1:0]         red,
	output logic [plvc_pkg::CHAN_W-1:0]         green,
	output logic [plvc_pkg::CHAN_W-1:0]         blue,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [plvc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [plvc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import plvc_pkg::*;

	localparam int CLS_W   = $clog2(MAX_CLASSES);
	localparam int BAND_W  = (BANDS > 1) ? $clog2(BANDS) : 1;
	localparam int NDEPTH  = MAX_CLASSES * (MAX_CLASSES - 1) / 2 * BANDS;
	localparam int NADDR_W = (NDEPTH > 1) ? $clog2(NDEPTH) : 1;

	logic [CNT_W-1:0]    class_count_q;
	logic [FACTOR_W-1:0] factor_q;
	logic                cfg_write;

	ctrl_cmd_t           cmd;
	dp_status_t          status;
	logic [CLS_W-1:0]    cls_i, cls_j, scan_idx;
	logic [BAND_W-1:0]   band;
	logic [NADDR_W-1:0]  naddr;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q <= CLASS_COUNT_RST;
			factor_q      <= FACTOR_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_CLASS_COUNT: class_count_q <= cfg_data[CNT_W-1:0];
				CFG_THRESHOLD:   factor_q      <= cfg_data[FACTOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer
	plvc_ctrl #(
		.MAX_CLASSES(MAX_CLASSES),
		.BANDS      (BANDS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.class_count(class_count_q),
		.status     (status),
		.cmd        (cmd),
		.cls_i      (cls_i),
		.cls_j      (cls_j),
		.band       (band),
		.naddr      (naddr),
		.scan_idx   (scan_idx)
	);

	// Tables, arithmetic and output register
	plvc_datapath #(
		.MAX_CLASSES(MAX_CLASSES),
		.BANDS      (BANDS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.factor       (factor_q),
		.func         (func),
		.entry_index  (entry_index),
		.band_index   (band_index),
		.coefficient  (coefficient),
		.color_word   (color_word),
		.pixel_band_0 (pixel_band_0),
		.pixel_band_1 (pixel_band_1),
		.pixel_band_2 (pixel_band_2),
		.pixel_band_3 (pixel_band_3),
		.cmd          (cmd),
		.cls_i        (cls_i),
		.cls_j        (cls_j),
		.band         (band),
		.naddr        (naddr),
		.scan_idx     (scan_idx),
		.status       (status),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.class_index  (class_index),
		.winning_votes(winning_votes),
		.red          (red),
		.green        (green),
		.blue         (blue)
	);

endmodule

// ----- test/plvc_vote_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plvc_vote_checker
// Watches the request, result and register channels of the pairwise linear
// vote classifier, keeps its own copy of the tables and registers, predicts
// the winning class and color of every classify request and compares each
// result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module plvc_vote_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [plvc_pkg::FUNC_W-1:0]         func,
	input  logic [plvc_pkg::ENTRY_W-1:0]        entry_index,
	input  logic [plvc_pkg::BANDSEL_W-1:0]      band_index,
	input  logic signed [plvc_pkg::COEF_W-1:0]  coefficient,
	input  logic [plvc_pkg::COLOR_W-1:0]        color_word,
	input  logic [plvc_pkg::PIX_W-1:0]          pixel_band_0,
	input  logic [plvc_pkg::PIX_W-1:0]          pixel_band_1,
	input  logic [plvc_pkg::PIX_W-1:0]          pixel_band_2,
	input  logic [plvc_pkg::PIX_W-1:0]          pixel_band_3,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [plvc_pkg::OUT_W-1:0]          class_index,
	input  logic [plvc_pkg::OUT_W-1:0]          winning_votes,
	input  logic [plvc_pkg::CHAN_W-1:0]         red,
	input  logic [plvc_pkg::CHAN_W-1:0]         green,
	input  logic [plvc_pkg::CHAN_W-1:0]         blue,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [plvc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [plvc_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                  fail_count,
	output int                                  pending
);
	import plvc_pkg::*;

	localparam int CLASS_SLOTS = MAX_CLASSES_DEF;
	localparam int BAND_SLOTS  = BANDS_DEF;
	localparam int PAIR_SLOTS  = CLASS_SLOTS * (CLASS_SLOTS - 1) / 2;

	typedef struct packed {
		logic [OUT_W-1:0]  class_idx;
		logic [OUT_W-1:0]  votes;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} verdict_t;

	// Shadow tables and registers
	logic [NRM_W-1:0]    normal_q [PAIR_SLOTS*BAND_SLOTS];
	logic [MEAN_W-1:0]   mean_q [CLASS_SLOTS*BAND_SLOTS];
	logic [COLOR_W-1:0]  color_q [CLASS_SLOTS];
	logic [CNT_W-1:0]    class_count_q;
	logic [FACTOR_W-1:0] factor_q;

	verdict_t expected_verdicts [$];
	verdict_t want;
	int       errors;

	// Vote over every pair in use and pick the class with the most votes
	function automatic verdict_t predict_vote(
		input logic [PIXEL_INPUTS-1:0][PIX_W-1:0] px
	);
		verdict_t         v;
		int               k;
		int               pair;
		int               best;
		int               tally [CLASS_SLOTS];
		logic signed [95:0] dot, proj, nrm, smp, msum, scale, lhs, rhs;
		k = (class_count_q > CLASS_SLOTS) ? CLASS_SLOTS : class_count_q;
		scale = factor_q;
		for (int c = 0; c < CLASS_SLOTS; c++)
			tally[c] = 0;
		pair = 0;
		for (int i = 0; i + 1 < k; i++) begin
			for (int j = i + 1; j < k; j++) begin
				dot = 0;
				proj = 0;
				for (int b = 0; b < BAND_SLOTS; b++) begin
					nrm = $signed(normal_q[pair*BAND_SLOTS + b]);
					smp = 0;
					if (b < PIXEL_INPUTS)
						smp = px[b];
					msum = mean_q[i*BAND_SLOTS + b] + mean_q[j*BAND_SLOTS + b];
					dot += smp * nrm;
					proj += msum * nrm;
				end
				// d is Q.22 and the mean projection Q.30: align both before the compare
				lhs = dot <<< FRAC_SHIFT;
				rhs = scale * proj;
				if (lhs > rhs)
					tally[i]++;
				else
					tally[j]++;
				pair++;
			end
		end
		best = 0;
		for (int c = 1; c < k; c++)
			if (tally[c] > tally[best])
				best = c;
		v.class_idx = OUT_W'(best);
		v.votes = OUT_W'(tally[best]);
		{v.red, v.green, v.blue} = color_q[best];
		return v;
	endfunction

	task automatic check_field(input string name, input int expected, input int actual);
		if (expected != actual) begin
			$error("%s: expected %0d, actual %0d", name, expected, actual);
			errors++;
		end
	endtask

	// Track registers, tables and results at each handshake
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q = CLASS_COUNT_RST;
			factor_q = FACTOR_RST;
			expected_verdicts.delete();
			errors = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// compare results first, a request of this edge cannot have one yet
			if (out_valid && !out_stall) begin
				if (expected_verdicts.size() == 0) begin
					$error("result with no classify request waiting: class_index %0d",
						class_index);
					errors++;
				end else begin
					want = expected_verdicts.pop_front();
					check_field("class_index", want.class_idx, class_index);
					check_field("winning_votes", want.votes, winning_votes);
					check_field("red", want.red, red);
					check_field("green", want.green, green);
					check_field("blue", want.blue, blue);
				end
			end

			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_CLASS_COUNT)
					class_count_q = cfg_data[CNT_W-1:0];
				else if (cfg_index == CFG_THRESHOLD)
					factor_q = cfg_data[FACTOR_W-1:0];
			end

			if (in_valid && !in_stall) begin
				case (func_t'(func))
					FUNC_CLASSIFY: begin
						expected_verdicts.push_back(predict_vote(
							{pixel_band_3, pixel_band_2, pixel_band_1, pixel_band_0}));
					end
					FUNC_NORMAL: begin
						if (entry_index < PAIR_SLOTS && band_index < BAND_SLOTS)
							normal_q[entry_index*BAND_SLOTS + band_index] =
								coefficient[NRM_W-1:0];
					end
					FUNC_MEAN: begin
						if (entry_index < CLASS_SLOTS && band_index < BAND_SLOTS)
							mean_q[entry_index*BAND_SLOTS + band_index] =
								coefficient[MEAN_W-1:0];
					end
					FUNC_COLOR: begin
						if (entry_index < CLASS_SLOTS)
							color_q[entry_index] = color_word;
					end
					default: begin
					end
				endcase
			end

			fail_count <= errors;
			pending <= expected_verdicts.size();
		end
	end

endmodule

// ----- test/pairwise_linear_vote_classifier_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pairwise_linear_vote_classifier_test
// Loads every table entry, runs directed requests on extreme values, ignored
// writes and exact threshold ties, then random table updates and pixels
// under several register settings, with bursty requests and a stalling
// result side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module pairwise_linear_vote_classifier_test;
	import plvc_pkg::*;

	localparam int CLASS_SLOTS    = MAX_CLASSES_DEF;
	localparam int PAIR_SLOTS     = CLASS_SLOTS * (CLASS_SLOTS - 1) / 2;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int DRAIN_CYCLES   = 150;
	localparam int PHASE_REQUESTS = 42;
	localparam int PHASES         = 9;

	// Register indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	typedef struct {
		func_t                               fn;
		logic [ENTRY_W-1:0]                  entry;
		logic [BANDSEL_W-1:0]                band;
		logic signed [COEF_W-1:0]            coef;
		logic [COLOR_W-1:0]                  color;
		logic [PIXEL_INPUTS-1:0][PIX_W-1:0]  pix;
	} request_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [FUNC_W-1:0]          func;
	logic [ENTRY_W-1:0]         entry_index;
	logic [BANDSEL_W-1:0]       band_index;
	logic signed [COEF_W-1:0]   coefficient;
	logic [COLOR_W-1:0]         color_word;
	logic [PIX_W-1:0]           pixel_band_0;
	logic [PIX_W-1:0]           pixel_band_1;
	logic [PIX_W-1:0]           pixel_band_2;
	logic [PIX_W-1:0]           pixel_band_3;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [OUT_W-1:0]           class_index;
	logic [OUT_W-1:0]           winning_votes;
	logic [CHAN_W-1:0]          red;
	logic [CHAN_W-1:0]          green;
	logic [CHAN_W-1:0]          blue;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	int                         fail_count;
	int                         pending;

	int cycle_count = 0;
	int stall_left = 0;
	int burst_left = 1;
	int use_count;
	bit holding = 1'b0;

	pairwise_linear_vote_classifier dut (.*);
	plvc_vote_checker vote_check (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Stall the result side: free stretches, short flicker and long holds
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					out_stall <= 1'b0;
					stall_left <= $urandom_range(20, 80);
				end
				1: begin
					out_stall <= 1'b1;
					stall_left <= $urandom_range(0, 2);
				end
				2: begin
					out_stall <= 1'b0;
					stall_left <= $urandom_range(0, 2);
				end
				default: begin
					out_stall <= 1'b1;
					stall_left <= $urandom_range(5, 25);
				end
			endcase
		end
	end

	function automatic logic [PIX_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic signed [COEF_W-1:0] rand_coef();
		int v;
		case ($urandom_range(0, 7))
			0: v = -8388608;
			1: v = 16777215;
			2: v = 8388607;
			3: v = int'($urandom_range(0, 6)) - 3;
			default: v = int'($urandom_range(0, 25165823)) - 8388608;
		endcase
		return v[COEF_W-1:0];
	endfunction

	function automatic request_t noise_request();
		request_t r;
		r.fn = FUNC_CLASSIFY;
		r.entry = ENTRY_W'($urandom);
		r.band = BANDSEL_W'($urandom);
		r.coef = rand_coef();
		r.color = COLOR_W'($urandom);
		for (int b = 0; b < PIXEL_INPUTS; b++)
			r.pix[b] = rand_sample();
		return r;
	endfunction

	// Mostly classify and in-range table updates, aimed at the classes in use
	function automatic request_t random_request(input int k);
		request_t r;
		int       classes;
		int       pairs;
		int       pick;
		classes = (k > CLASS_SLOTS) ? CLASS_SLOTS : ((k < 1) ? 1 : k);
		pairs = classes * (classes - 1) / 2;
		r = noise_request();
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			r.fn = FUNC_CLASSIFY;
		end else if (pick < 75) begin
			r.fn = FUNC_NORMAL;
			if (pairs > 0 && $urandom_range(0, 3) != 0)
				r.entry = ENTRY_W'($urandom_range(0, pairs - 1));
			else
				r.entry = ENTRY_W'($urandom_range(0, PAIR_SLOTS - 1));
		end else if (pick < 95) begin
			r.fn = (pick < 87) ? FUNC_MEAN : FUNC_COLOR;
			if ($urandom_range(0, 1))
				r.entry = ENTRY_W'($urandom_range(0, classes - 1));
			else
				r.entry = ENTRY_W'($urandom_range(0, CLASS_SLOTS - 1));
		end else begin
			// out-of-range write, to be dropped
			r.fn = func_t'($urandom_range(1, 3));
			if (r.fn == FUNC_NORMAL)
				r.entry = ENTRY_W'($urandom_range(PAIR_SLOTS, 31));
			else
				r.entry = ENTRY_W'($urandom_range(CLASS_SLOTS, 31));
		end
		return r;
	endfunction

	// Hold the request until accepted; keep valid high inside a burst
	task automatic send(input request_t r);
		func <= r.fn;
		entry_index <= r.entry;
		band_index <= r.band;
		coefficient <= r.coef;
		color_word <= r.color;
		pixel_band_0 <= r.pix[0];
		pixel_band_1 <= r.pix[1];
		pixel_band_2 <= r.pix[2];
		pixel_band_3 <= r.pix[3];
		in_valid <= 1'b1;
		holding = 1'b1;
		do @(posedge clk); while (in_stall);
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			holding = 1'b0;
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(15, 40)) @(posedge clk);
			else
				repeat ($urandom_range(1, 6)) @(posedge clk);
			case ($urandom_range(0, 3))
				0: burst_left = 1;
				1: burst_left = $urandom_range(2, 5);
				2: burst_left = $urandom_range(6, 20);
				default: burst_left = $urandom_range(30, 60);
			endcase
		end
	endtask

	task automatic load(input func_t fn, input logic [ENTRY_W-1:0] entry,
			input logic [BANDSEL_W-1:0] band, input logic signed [COEF_W-1:0] coef,
			input logic [COLOR_W-1:0] color);
		request_t r;
		r = noise_request();
		r.fn = fn;
		r.entry = entry;
		r.band = band;
		r.coef = coef;
		r.color = color;
		send(r);
	endtask

	task automatic classify(input logic [PIX_W-1:0] p0, input logic [PIX_W-1:0] p1,
			input logic [PIX_W-1:0] p2, input logic [PIX_W-1:0] p3);
		request_t r;
		r = noise_request();
		r.pix = {p3, p2, p1, p0};
		send(r);
	endtask

	// Drop valid, wait for every result, then let table writes retire
	task automatic settle();
		if (holding) begin
			in_valid <= 1'b0;
			holding = 1'b0;
			@(posedge clk);
		end
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int count, input int factor);
		logic [CFG_DATA_W-CNT_W-1:0] junk;
		junk = (CFG_DATA_W-CNT_W)'($urandom);
		settle();
		write_register(CFG_CLASS_COUNT, {junk, count[CNT_W-1:0]});
		write_register(CFG_THRESHOLD, factor[FACTOR_W-1:0]);
		use_count = count;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_CLASSIFY;
		entry_index = '0;
		band_index = '0;
		coefficient = '0;
		color_word = '0;
		pixel_band_0 = '0;
		pixel_band_1 = '0;
		pixel_band_2 = '0;
		pixel_band_3 = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CLASS_COUNT;
		cfg_data = '0;
		use_count = CLASS_COUNT_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every table entry so no classify reads an unwritten one
		for (int e = 0; e < PAIR_SLOTS; e++)
			for (int b = 0; b < BANDS_DEF; b++)
				load(FUNC_NORMAL, ENTRY_W'(e), BANDSEL_W'(b), rand_coef(),
					COLOR_W'($urandom));
		for (int e = 0; e < CLASS_SLOTS; e++)
			for (int b = 0; b < BANDS_DEF; b++)
				load(FUNC_MEAN, ENTRY_W'(e), BANDSEL_W'(b), rand_coef(),
					COLOR_W'($urandom));
		for (int e = 0; e < CLASS_SLOTS; e++)
			load(FUNC_COLOR, ENTRY_W'(e), BANDSEL_W'($urandom), rand_coef(),
				COLOR_W'($urandom));

		// Extreme pixels at reset settings
		classify('0, '0, '0, '0);
		classify('1, '1, '1, '1);

		// Out-of-range writes must leave the tables alone
		load(FUNC_NORMAL, PAIR_SLOTS, 0, 8388607, '0);
		load(FUNC_NORMAL, 31, 3, -8388608, '0);
		load(FUNC_MEAN, CLASS_SLOTS, 1, 16777215, '0);
		load(FUNC_MEAN, 31, 2, '0, '0);
		load(FUNC_COLOR, CLASS_SLOTS, 0, '0, 24'h000000);
		load(FUNC_COLOR, 31, 0, '0, 24'hFFFFFF);

		// Extreme colors, negative means that wrap, full-scale normals
		load(FUNC_COLOR, 0, 0, '0, 24'hFFFFFF);
		load(FUNC_COLOR, 7, 0, '0, 24'h000000);
		load(FUNC_MEAN, 3, 0, -8388608, '0);
		load(FUNC_MEAN, 5, 3, -1, '0);
		load(FUNC_NORMAL, 27, 0, 8388607, '0);
		load(FUNC_NORMAL, 27, 1, -8388608, '0);

		// Zero normal on the first pair: both sides equal, the second class wins
		for (int b = 0; b < BANDS_DEF; b++)
			load(FUNC_NORMAL, 0, BANDSEL_W'(b), '0, '0);
		classify(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
		classify(rand_sample(), rand_sample(), rand_sample(), rand_sample());

		// Exact threshold: factor 1/256, one band, projection equal to threshold
		configure(2, 256);
		load(FUNC_NORMAL, 0, 0, 1, '0);
		load(FUNC_MEAN, 0, 0, 32768, '0);
		load(FUNC_MEAN, 1, 0, 32768, '0);
		classify(1, rand_sample(), rand_sample(), rand_sample());
		classify(2, rand_sample(), rand_sample(), rand_sample());
		load(FUNC_MEAN, 1, 0, 32767, '0);
		classify(1, rand_sample(), rand_sample(), rand_sample());
		load(FUNC_NORMAL, 0, 0, -1, '0);
		classify(0, rand_sample(), rand_sample(), rand_sample());
		classify(1, rand_sample(), rand_sample(), rand_sample());

		// Random phases over register settings, extremes among them
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: configure(2, 65535);
				1: configure(0, 0);
				2: configure(1, $urandom_range(0, 65535));
				3: configure(15, $urandom_range(0, 65535));
				4: configure(9, 0);
				5: configure($urandom_range(3, 7), $urandom_range(0, 65535));
				6: configure(8, 65535);
				7: configure(8, FACTOR_RST);
				default: configure($urandom_range(2, 8), $urandom_range(0, 65535));
			endcase
			if (phase == 2) begin
				write_register(CFG_SPARE_2, CFG_DATA_W'($urandom));
				write_register(CFG_SPARE_3, CFG_DATA_W'($urandom));
			end
			repeat (PHASE_REQUESTS) begin
				if ($urandom_range(0, 59) == 0)
					settle();
				send(random_request(use_count));
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
